FILE: hdl/lc3ie_pkg.sv
// Package for the LC-3 execute unit: opcodes, trap vectors, status codes and
// the command/status structs between controller and datapath. No dependencies.
package lc3ie_pkg;

   localparam logic [3:0] OP_BR  = 4'h0;
   localparam logic [3:0] OP_ADD = 4'h1;
   localparam logic [3:0] OP_LD  = 4'h2;
   localparam logic [3:0] OP_ST  = 4'h3;
   localparam logic [3:0] OP_JSR = 4'h4;
   localparam logic [3:0] OP_AND = 4'h5;
   localparam logic [3:0] OP_LDR = 4'h6;
   localparam logic [3:0] OP_STR = 4'h7;
   localparam logic [3:0] OP_NOT = 4'h9;
   localparam logic [3:0] OP_LDI = 4'hA;
   localparam logic [3:0] OP_STI = 4'hB;
   localparam logic [3:0] OP_JMP = 4'hC;
   localparam logic [3:0] OP_LEA = 4'hE;
   localparam logic [3:0] OP_TRAP = 4'hF;

   localparam logic [7:0] TRAP_GETC = 8'h20;
   localparam logic [7:0] TRAP_OUT  = 8'h21;
   localparam logic [7:0] TRAP_IN   = 8'h23;
   localparam logic [7:0] TRAP_HALT = 8'h25;

   localparam logic [7:0] PROMPT_CHAR = 8'h3E;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_HALTED  = 2'd1;
   localparam logic [1:0] ST_UNSUPP  = 2'd2;
   localparam logic [1:0] ST_WASHALT = 2'd3;

   localparam logic [2:0] CC_NEG  = 3'b100;
   localparam logic [2:0] CC_ZERO = 3'b010;
   localparam logic [2:0] CC_POS  = 3'b001;

   // Memory address source.
   typedef enum logic [1:0] {
      MA_PC   = 2'd0,
      MA_EA   = 2'd1,
      MA_MDR  = 2'd2,
      MA_LOAD = 2'd3
   } maddr_sel_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic          load_word;   // capture request payload
      logic          mem_rd;
      logic          mem_wr;
      maddr_sel_type maddr_sel;
      logic          mwdata_reg;  // store data from register file
      logic          load_ir;     // fetch data into IR, bump PC
      logic          load_mdr;    // read data into MDR
      logic          execute;     // apply ALU/branch/trap result
      logic          wb_mdr;      // write read data to DR and set CC
      logic          set_halt;
      logic          load_rsp;
      logic          warm_pc;     // load start_pc after reset
   } dp_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic       is_load;
      logic       halted;
      logic [3:0] opcode;
   } dp_stat_type;

endpackage

FILE: hdl/lc3_instruction_execute_unit.sv
// Top level of the LC-3 execute unit: start_pc register, controller and datapath.
// Depends on lc3ie_pkg, lc3ie_control and lc3ie_datapath.
//
//   channel  direction  handshake             contents
//   req      in         req_valid/req_stall   cmd, load_addr, load_data, key_char
//   rsp      out        rsp_valid/rsp_stall   status, char, next_pc, cond_flags
//   csr      in         csr_write_enable      start_pc
//
// A word is taken only in the idle state; every fetch and data access shares the
// one memory port, so a step fetches, then makes its data accesses (two for LDI
// and STI, one for LD, LDR, ST and STR) before its result is written.
// The result register lets the next word enter while a result waits; a word that
// finds it still full waits in its last cycle until the result is taken.
// Reset is synchronous; after reset the controller's warm-up state loads the PC from start_pc.
module lc3_instruction_execute_unit #(
   parameter int ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [15:0] req_load_addr,
   input  logic [15:0] req_load_data,
   input  logic [7:0]  req_key_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_run_status,
   output logic        rsp_char_valid,
   output logic [7:0]  rsp_char_out,
   output logic [15:0] rsp_next_pc,
   output logic [2:0]  rsp_cond_flags
);

   logic [15:0] start_pc_ff;
   lc3ie_pkg::dp_cmd_type  cmd;
   lc3ie_pkg::dp_stat_type stat;

   // Start PC register.
   always_ff @(posedge clock) begin
      if (reset) start_pc_ff <= 16'h3000;
      else if (csr_write_enable) start_pc_ff <= csr_write_data;
   end

   lc3ie_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .stat(stat)
   );

   lc3ie_datapath #(.ADDR_BITS(ADDR_BITS)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .start_pc(start_pc_ff),
      .req_cmd(req_cmd), .req_load_addr(req_load_addr),
      .req_load_data(req_load_data), .req_key_char(req_key_char),
      .rsp_run_status(rsp_run_status), .rsp_char_valid(rsp_char_valid),
      .rsp_char_out(rsp_char_out), .rsp_next_pc(rsp_next_pc),
      .rsp_cond_flags(rsp_cond_flags)
   );

endmodule

FILE: hdl/lc3ie_datapath.sv
// Datapath of the LC-3 execute unit: memory, register file, PC, IR, MDR,
// ALU and result register. Depends on lc3ie_pkg.
module lc3ie_datapath #(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lc3ie_pkg::dp_cmd_type cmd,
   output lc3ie_pkg::dp_stat_type stat,
   input  logic [15:0]          start_pc,
   input  logic                 req_cmd,
   input  logic [15:0]          req_load_addr,
   input  logic [15:0]          req_load_data,
   input  logic [7:0]           req_key_char,
   output logic [1:0]           rsp_run_status,
   output logic                 rsp_char_valid,
   output logic [7:0]           rsp_char_out,
   output logic [15:0]          rsp_next_pc,
   output logic [2:0]           rsp_cond_flags
);

   localparam int MEM_WORDS = 1 << ADDR_BITS;

   logic [15:0] mem [MEM_WORDS];
   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff, ir_ff, mdr_ff, ldaddr_ff, lddata_ff;
   logic [7:0]  key_ff;
   logic        isload_ff, halted_ff;
   logic [2:0]  cc_ff;
   logic [1:0]  status_ff;
   logic        cv_ff;
   logic [7:0]  ch_ff;

   logic [15:0] rdata_ff, maddr, a_val, b_val, sr_val, pc9, pc11, ea_base;
   logic [2:0]  dr;
   logic [3:0]  op;

   assign op = ir_ff[15:12];
   assign dr = ir_ff[11:9];
   assign a_val = regs_ff[ir_ff[8:6]];
   assign b_val = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : regs_ff[ir_ff[2:0]];
   assign sr_val = regs_ff[dr];
   assign pc9 = pc_ff + {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign pc11 = pc_ff + {{5{ir_ff[10]}}, ir_ff[10:0]};
   // Effective address for loads and stores.
   assign ea_base = (op == lc3ie_pkg::OP_LDR || op == lc3ie_pkg::OP_STR)
                  ? a_val + {{10{ir_ff[5]}}, ir_ff[5:0]} : pc9;

   always_comb begin
      unique case (cmd.maddr_sel)
         lc3ie_pkg::MA_PC:   maddr = pc_ff;
         lc3ie_pkg::MA_EA:   maddr = ea_base;
         lc3ie_pkg::MA_MDR:  maddr = mdr_ff;
         lc3ie_pkg::MA_LOAD: maddr = ldaddr_ff;
         default:            maddr = pc_ff;
      endcase
   end

   // Single-port word memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.mem_wr)
         mem[maddr[ADDR_BITS-1:0]] <= cmd.mwdata_reg ? sr_val : lddata_ff;
      if (cmd.mem_rd)
         rdata_ff <= mem[maddr[ADDR_BITS-1:0]];
   end

   function automatic logic [2:0] cc_of(input logic [15:0] v);
      if (v == 16'd0) return lc3ie_pkg::CC_ZERO;
      else if (v[15]) return lc3ie_pkg::CC_NEG;
      else return lc3ie_pkg::CC_POS;
   endfunction

   // Request capture, IR, MDR.
   always_ff @(posedge clock) begin
      if (cmd.load_word) begin
         isload_ff <= ~req_cmd;
         ldaddr_ff <= req_load_addr;
         lddata_ff <= req_load_data;
         key_ff    <= req_key_char;
      end
      if (cmd.load_ir) ir_ff <= rdata_ff;
      if (cmd.load_mdr) mdr_ff <= rdata_ff;
   end

   // Architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= '0;
         cc_ff <= lc3ie_pkg::CC_ZERO;
         halted_ff <= 1'b0;
         status_ff <= lc3ie_pkg::ST_DONE;
         cv_ff <= 1'b0;
         ch_ff <= '0;
      end else begin
         if (cmd.warm_pc) pc_ff <= start_pc;
         if (cmd.load_ir) pc_ff <= pc_ff + 16'd1;
         if (cmd.load_word) begin
            status_ff <= lc3ie_pkg::ST_DONE;
            cv_ff <= 1'b0;
            ch_ff <= '0;
         end
         if (cmd.set_halt) status_ff <= lc3ie_pkg::ST_WASHALT;
         if (cmd.wb_mdr) begin
            regs_ff[dr] <= rdata_ff;
            cc_ff <= cc_of(rdata_ff);
         end
         if (cmd.execute) begin
            case (op)
               lc3ie_pkg::OP_ADD: begin
                  regs_ff[dr] <= a_val + b_val;
                  cc_ff <= cc_of(a_val + b_val);
               end
               lc3ie_pkg::OP_AND: begin
                  regs_ff[dr] <= a_val & b_val;
                  cc_ff <= cc_of(a_val & b_val);
               end
               lc3ie_pkg::OP_NOT: begin
                  regs_ff[dr] <= ~a_val;
                  cc_ff <= cc_of(~a_val);
               end
               lc3ie_pkg::OP_LEA: begin
                  regs_ff[dr] <= pc9;
                  cc_ff <= cc_of(pc9);
               end
               lc3ie_pkg::OP_BR:
                  if ((dr & cc_ff) != 3'd0) pc_ff <= pc9;
               lc3ie_pkg::OP_JMP: pc_ff <= a_val;
               lc3ie_pkg::OP_JSR: begin
                  regs_ff[7] <= pc_ff;
                  pc_ff <= ir_ff[11] ? pc11 : a_val;
               end
               lc3ie_pkg::OP_LD, lc3ie_pkg::OP_LDI, lc3ie_pkg::OP_LDR,
               lc3ie_pkg::OP_ST, lc3ie_pkg::OP_STI, lc3ie_pkg::OP_STR: ;
               lc3ie_pkg::OP_TRAP: begin
                  case (ir_ff[7:0])
                     lc3ie_pkg::TRAP_GETC: regs_ff[0] <= {8'd0, key_ff};
                     lc3ie_pkg::TRAP_OUT: begin
                        cv_ff <= 1'b1;
                        ch_ff <= regs_ff[0][7:0];
                     end
                     lc3ie_pkg::TRAP_IN: begin
                        cv_ff <= 1'b1;
                        ch_ff <= lc3ie_pkg::PROMPT_CHAR;
                        regs_ff[0] <= {8'd0, key_ff};
                     end
                     lc3ie_pkg::TRAP_HALT: begin
                        halted_ff <= 1'b1;
                        status_ff <= lc3ie_pkg::ST_HALTED;
                     end
                     default: status_ff <= lc3ie_pkg::ST_UNSUPP;
                  endcase
               end
               default: status_ff <= lc3ie_pkg::ST_UNSUPP;
            endcase
         end
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_run_status <= status_ff;
         rsp_char_valid <= cv_ff;
         rsp_char_out   <= ch_ff;
         rsp_next_pc    <= pc_ff;
         rsp_cond_flags <= cc_ff;
      end
   end

   assign stat.is_load = isload_ff;
   assign stat.halted  = halted_ff;
   assign stat.opcode  = op;

endmodule

FILE: hdl/lc3ie_control.sv
// Controller of the LC-3 execute unit: sequences fetch, memory reads,
// execute, writeback and the output handshake. Depends on lc3ie_pkg.
module lc3ie_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lc3ie_pkg::dp_cmd_type cmd,
   input  lc3ie_pkg::dp_stat_type stat
);

   typedef enum logic [8:0] {
      S_WARM  = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_DISP  = 9'b000000100,
      S_FETCH = 9'b000001000,
      S_DEC   = 9'b000010000,
      S_IND   = 9'b000100000,
      S_MEM   = 9'b001000000,
      S_WB    = 9'b010000000,
      S_RESP  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      is_ldi, is_sti, is_ld, is_st;

   assign is_ldi = stat.opcode == lc3ie_pkg::OP_LDI;
   assign is_sti = stat.opcode == lc3ie_pkg::OP_STI;
   assign is_ld  = stat.opcode == lc3ie_pkg::OP_LD || stat.opcode == lc3ie_pkg::OP_LDR;
   assign is_st  = stat.opcode == lc3ie_pkg::OP_ST || stat.opcode == lc3ie_pkg::OP_STR;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      cmd = '0;
      cmd.maddr_sel = lc3ie_pkg::MA_PC;
      unique case (state_ff)
         S_WARM: begin
            cmd.warm_pc = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE:
            if (req_valid) begin
               cmd.load_word = 1'b1;
               state_in = S_DISP;
            end
         // Route the word: memory write, halted step or fetch.
         S_DISP: begin
            if (stat.is_load) begin
               cmd.mem_wr = 1'b1;
               cmd.maddr_sel = lc3ie_pkg::MA_LOAD;
               state_in = S_RESP;
            end else if (stat.halted) begin
               cmd.set_halt = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.load_ir = 1'b1;
            state_in = S_DEC;
         end
         // Issue the first data access, or execute directly.
         S_DEC: begin
            cmd.maddr_sel = lc3ie_pkg::MA_EA;
            if (is_ld || is_ldi || is_sti) begin
               cmd.mem_rd = 1'b1;
               state_in = (is_ld) ? S_WB : S_IND;
            end else if (is_st) begin
               cmd.mem_wr = 1'b1;
               cmd.mwdata_reg = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.execute = 1'b1;
               state_in = S_RESP;
            end
         end
         S_IND: begin
            cmd.load_mdr = 1'b1;
            state_in = S_MEM;
         end
         // Second access through the pointer.
         S_MEM: begin
            cmd.maddr_sel = lc3ie_pkg::MA_MDR;
            if (is_sti) begin
               cmd.mem_wr = 1'b1;
               cmd.mwdata_reg = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in = S_WB;
            end
         end
         S_WB: begin
            cmd.wb_mdr = 1'b1;
            state_in = S_RESP;
         end
         // Wait for the output register to be free.
         S_RESP:
            if (!out_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WARM;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: hdl/lc3ie_checker.sv
// Port checker for the LC-3 execute unit and its bind to the top level.
// Depends on lc3ie_pkg and the top level's ports.
module lc3ie_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_run_status,
   input logic        rsp_char_valid,
   input logic [7:0]  rsp_char_out
);

   // A held result word stays valid and keeps its run status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_status))
      else $error("held result changed");

   // A character is flagged only with a plain done status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> rsp_run_status == lc3ie_pkg::ST_DONE)
      else $error("character with non-done status");

   // No character means a zero character code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_char_out == 8'd0)
      else $error("stray character");

   // An accepted word keeps the input side stalled next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted too early");

endmodule

bind lc3_instruction_execute_unit lc3ie_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_run_status(rsp_run_status), .rsp_char_valid(rsp_char_valid),
   .rsp_char_out(rsp_char_out)
);

FILE: bench/tb_lc3_instruction_execute_unit.sv
// Testbench for the LC-3 execute unit: drives load and step words, predicts each
// result with an in-bench model of the core and checks every response word.
// Depends on lc3ie_pkg and lc3_instruction_execute_unit.
`timescale 1ns / 1ps

module tb_lc3_instruction_execute_unit;

   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [1:0]  status;
      logic        cv;
      logic [7:0]  ch;
      logic [15:0] npc;
      logic [2:0]  cc;
   } outcome_type;

   typedef struct {
      logic [15:0] ir;
      logic [7:0]  key;
      bit          has_st;
      logic [1:0]  st;
   } program_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = 1'b0;
   logic [15:0] req_load_addr = '0;
   logic [15:0] req_load_data = '0;
   logic [7:0]  req_key_char = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_run_status;
   logic        rsp_char_valid;
   logic [7:0]  rsp_char_out;
   logic [15:0] rsp_next_pc;
   logic [2:0]  rsp_cond_flags;

   // Shadow copy of the core state.
   logic [15:0] gpr [8];
   logic [15:0] pc_q;
   logic [2:0]  cc_q;
   logic [15:0] mem_q [65536];
   bit          mem_written [65536];
   bit          halted_q;
   logic [15:0] start_pc_q;

   outcome_type pending_results [$];
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          mismatches = 0;
   int          words_sent = 0;
   int          idle_cycles = 0;

   // Directed program; a status is typed in only where it is plain to see.
   program_row_type opening [24] = '{
      '{16'h1021, 8'h00, 1'b1, lc3ie_pkg::ST_DONE},     // ADD immediate
      '{16'h127F, 8'h00, 1'b1, lc3ie_pkg::ST_DONE},     // ADD with immediate -1
      '{16'h1401, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // ADD register
      '{16'h5020, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // AND clears R0
      '{16'h9BFF, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // NOT
      '{16'h0E01, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // BR always
      '{16'h0000, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // BR with no condition bits
      '{16'hE1FF, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // LEA sets the flags
      '{16'h2200, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // LD
      '{16'hA5FF, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // LDI
      '{16'h6040, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // LDR
      '{16'h3600, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // ST
      '{16'hB000, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // STI
      '{16'h7FBF, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // STR
      '{16'h4802, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // JSR
      '{16'h4040, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // JSRR
      '{16'hC1C0, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // RET
      '{16'hF020, 8'hFF, 1'b0, lc3ie_pkg::ST_DONE},     // GETC
      '{16'hF021, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // OUT
      '{16'hF023, 8'h00, 1'b0, lc3ie_pkg::ST_DONE},     // IN
      '{16'hF022, 8'h00, 1'b1, lc3ie_pkg::ST_UNSUPP},   // PUTS
      '{16'hF0FF, 8'h00, 1'b1, lc3ie_pkg::ST_UNSUPP},   // unknown trap vector
      '{16'h8000, 8'h00, 1'b1, lc3ie_pkg::ST_UNSUPP},   // RTI
      '{16'hD000, 8'h00, 1'b1, lc3ie_pkg::ST_UNSUPP}    // reserved opcode
   };

   lc3_instruction_execute_unit dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_load_addr(req_load_addr), .req_load_data(req_load_data),
      .req_key_char(req_key_char),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_run_status(rsp_run_status),
      .rsp_char_valid(rsp_char_valid), .rsp_char_out(rsp_char_out),
      .rsp_next_pc(rsp_next_pc), .rsp_cond_flags(rsp_cond_flags)
   );

   // Clock with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] sext_field(logic [15:0] v, int bits);
      logic [15:0] m;
      m = 16'((32'd1 << bits) - 1);
      v = v & m;
      if (v[bits-1]) v = v | ~m;
      return v;
   endfunction

   function automatic logic [2:0] flags_of(logic [15:0] v);
      if (v == 16'h0) return lc3ie_pkg::CC_ZERO;
      if (v[15]) return lc3ie_pkg::CC_NEG;
      return lc3ie_pkg::CC_POS;
   endfunction

   function automatic void write_gpr(int r, logic [15:0] v);
      gpr[r] = v;
      cc_q = flags_of(v);
   endfunction

   function automatic void store_word(logic [15:0] a, logic [15:0] d);
      mem_q[a] = d;
      mem_written[a] = 1'b1;
   endfunction

   // Apply one accepted word to the shadow state and return its result.
   function automatic outcome_type execute_word(logic cmd, logic [15:0] a, logic [15:0] d,
                                                logic [7:0] key);
      outcome_type o;
      logic [15:0] ir, ra, rb, pc9;
      int dr, sr1;
      o = '0;
      if (!cmd) begin
         store_word(a, d);
      end else if (halted_q) begin
         o.status = lc3ie_pkg::ST_WASHALT;
      end else begin
         ir = mem_q[pc_q];
         dr = int'(ir[11:9]);
         sr1 = int'(ir[8:6]);
         ra = gpr[sr1];
         rb = ir[5] ? sext_field(ir, 5) : gpr[ir[2:0]];
         pc_q = pc_q + 16'd1;
         pc9 = pc_q + sext_field(ir, 9);
         case (ir[15:12])
            lc3ie_pkg::OP_ADD: write_gpr(dr, ra + rb);
            lc3ie_pkg::OP_AND: write_gpr(dr, ra & rb);
            lc3ie_pkg::OP_NOT: write_gpr(dr, ~ra);
            lc3ie_pkg::OP_BR: if ((3'(dr) & cc_q) != 3'd0) pc_q = pc9;
            lc3ie_pkg::OP_JMP: pc_q = ra;
            lc3ie_pkg::OP_JSR: begin
               gpr[7] = pc_q;
               pc_q = ir[11] ? pc_q + sext_field(ir, 11) : ra;
            end
            lc3ie_pkg::OP_LD: write_gpr(dr, mem_q[pc9]);
            lc3ie_pkg::OP_LDI: write_gpr(dr, mem_q[mem_q[pc9]]);
            lc3ie_pkg::OP_LDR: write_gpr(dr, mem_q[ra + sext_field(ir, 6)]);
            lc3ie_pkg::OP_LEA: write_gpr(dr, pc9);
            lc3ie_pkg::OP_ST: store_word(pc9, gpr[dr]);
            lc3ie_pkg::OP_STI: store_word(mem_q[pc9], gpr[dr]);
            lc3ie_pkg::OP_STR: store_word(ra + sext_field(ir, 6), gpr[dr]);
            lc3ie_pkg::OP_TRAP: begin
               case (ir[7:0])
                  lc3ie_pkg::TRAP_GETC: gpr[0] = {8'h00, key};
                  lc3ie_pkg::TRAP_OUT: begin
                     o.cv = 1'b1;
                     o.ch = gpr[0][7:0];
                  end
                  lc3ie_pkg::TRAP_IN: begin
                     o.cv = 1'b1;
                     o.ch = lc3ie_pkg::PROMPT_CHAR;
                     gpr[0] = {8'h00, key};
                  end
                  lc3ie_pkg::TRAP_HALT: begin
                     halted_q = 1'b1;
                     o.status = lc3ie_pkg::ST_HALTED;
                  end
                  default: o.status = lc3ie_pkg::ST_UNSUPP;
               endcase
            end
            default: o.status = lc3ie_pkg::ST_UNSUPP;
         endcase
      end
      o.npc = pc_q;
      o.cc = cc_q;
      return o;
   endfunction

   // Present one word, wait for acceptance, then record its expected result.
   task automatic send(input logic cmd, input logic [15:0] a, input logic [15:0] d,
                       input logic [7:0] key, input bit has_st, input logic [1:0] st);
      outcome_type o;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_load_addr <= a;
      req_load_data <= d;
      req_key_char <= key;
      do @(posedge clock); while (!(req_valid && !req_stall));
      o = execute_word(cmd, a, d, key);
      if (has_st) o.status = st;
      pending_results.push_back(o);
      words_sent++;
   endtask

   task automatic fill_if_unwritten(input logic [15:0] a);
      if (!mem_written[a])
         send(1'b0, a, 16'($urandom), 8'($urandom), 1'b0, lc3ie_pkg::ST_DONE);
   endtask

   function automatic logic [15:0] random_instruction();
      logic [15:0] ir;
      logic [7:0] vectors [6];
      ir = 16'($urandom);
      vectors = '{lc3ie_pkg::TRAP_GETC, lc3ie_pkg::TRAP_OUT, lc3ie_pkg::TRAP_IN,
                  8'h22, 8'h24, 8'($urandom)};
      if (ir[15:12] == lc3ie_pkg::OP_TRAP) ir[7:0] = vectors[$urandom_range(5)];
      // Halting ends all useful work, so it is kept for the closing rows.
      if (ir[15:12] == lc3ie_pkg::OP_TRAP && ir[7:0] == lc3ie_pkg::TRAP_HALT)
         ir[7:0] = lc3ie_pkg::TRAP_OUT;
      return ir;
   endfunction

   // Place an instruction at the PC (or reuse one written there), back every memory read it makes, then step.
   task automatic run_instruction(input bit given, input logic [15:0] ir_in,
                                  input logic [7:0] key, input bit has_st,
                                  input logic [1:0] st);
      logic [15:0] ir, pc9;
      if (!halted_q) begin
         if (given || !mem_written[pc_q] || $urandom_range(9) < 8)
            send(1'b0, pc_q, given ? ir_in : random_instruction(), 8'($urandom),
                 1'b0, lc3ie_pkg::ST_DONE);
         ir = mem_q[pc_q];
         pc9 = pc_q + 16'd1 + sext_field(ir, 9);
         case (ir[15:12])
            lc3ie_pkg::OP_LD, lc3ie_pkg::OP_STI: fill_if_unwritten(pc9);
            lc3ie_pkg::OP_LDI: begin
               fill_if_unwritten(pc9);
               fill_if_unwritten(mem_q[pc9]);
            end
            lc3ie_pkg::OP_LDR: fill_if_unwritten(gpr[ir[8:6]] + sext_field(ir, 6));
            default: ;
         endcase
      end
      send(1'b1, 16'($urandom), 16'($urandom), key, has_st, st);
   endtask

   task automatic write_start_pc(input logic [15:0] v);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      start_pc_q = v;
   endtask

   task automatic random_phase(input int n, input int send_pct, input int rcv_pct);
      int target;
      send_idle_pct = send_pct;
      stall_pct = rcv_pct;
      target = words_sent + n;
      while (words_sent < target) begin
         if ($urandom_range(99) < 12)
            send(1'b0, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0,
                 lc3ie_pkg::ST_DONE);
         else
            run_instruction(1'b0, '0, 8'($urandom), 1'b0, lc3ie_pkg::ST_DONE);
      end
   endtask

   // Receiver: random stall and check against the oldest expected result.
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_run_status, rsp_char_valid, rsp_char_out, rsp_next_pc,
                    rsp_cond_flags};
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response word %h", got);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: status %0d/%0d char %b %h/%b %h pc %h/%h cc %b/%b",
                              want.status, got.status, want.cv, want.ch, got.cv, got.ch,
                              want.npc, got.npc, want.cc, got.cc);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog on cycles without any accepted word or taken response.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** lc3_instruction_execute_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < 8; i++) gpr[i] = '0;
      pc_q = 16'h3000;
      start_pc_q = 16'h3000;
      cc_q = lc3ie_pkg::CC_ZERO;
      halted_q = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (5) @(posedge clock);
      write_start_pc(16'($urandom));

      // Directed program, then extreme load addresses and data.
      send_idle_pct = 26;
      stall_pct = 80;
      foreach (opening[i])
         run_instruction(1'b1, opening[i].ir, opening[i].key, opening[i].has_st,
                         opening[i].st);
      send(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, lc3ie_pkg::ST_DONE);
      send(1'b0, 16'h0000, 16'h0000, 8'h00, 1'b1, lc3ie_pkg::ST_DONE);

      random_phase(510, 26, 80);
      write_start_pc(16'h0000);
      random_phase(510, 80, 26);
      write_start_pc(16'hFFFF);
      random_phase(510, 0, 0);

      // Closing rows: halt, a step while halted, a load, another step while halted.
      run_instruction(1'b1, {lc3ie_pkg::OP_TRAP, 4'h0, lc3ie_pkg::TRAP_HALT}, 8'h00,
                      1'b1, lc3ie_pkg::ST_HALTED);
      send(1'b1, 16'h0000, 16'h0000, 8'h00, 1'b1, lc3ie_pkg::ST_WASHALT);
      send(1'b0, 16'hFFFF, 16'h0000, 8'hFF, 1'b1, lc3ie_pkg::ST_DONE);
      send(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, lc3ie_pkg::ST_WASHALT);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("** lc3_instruction_execute_unit: PASSED **");
      else
         $display("** lc3_instruction_execute_unit: FAILED **");
      $finish;
   end

endmodule
